>>> src/device_health_tracker_assert.svh
// ----------------------------------------------------------------------------
// device_health_tracker_assert
// assertion macros for the checker file of the health tracker
// ----------------------------------------------------------------------------
`ifndef DEVICE_HEALTH_TRACKER_ASSERT_SVH
`define DEVICE_HEALTH_TRACKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DHT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("health tracker check failed");

// next-cycle implication, disabled during reset
`define DHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("health tracker check failed");

`endif

>>> src/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// types, codes and sizes shared by the device health tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dht_pkg;

   localparam int unsigned TS_W      = 64;
   localparam int unsigned WIN_DEPTH = 16;
   localparam int unsigned WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
   localparam int unsigned WIN_FW    = $clog2(WIN_DEPTH + 1);
   localparam int unsigned CSR_IW    = 2;

   typedef enum logic [2:0] {
      OP_SUCCESS     = 3'd0,
      OP_MARK_BROKEN = 3'd1,
      OP_UNAVAILABLE = 3'd2,
      OP_BACK_ONLINE = 3'd3,
      OP_TIMEOUT     = 3'd4
   } dht_op_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_UNAVAILABLE   = 2'd1,
      ST_SILENT_BROKEN = 2'd2,
      ST_BROKEN        = 2'd3
   } dht_status_type;

   typedef enum logic [1:0] {
      EV_NONE      = 2'd0,
      EV_BROKEN    = 2'd1,
      EV_RECOVERED = 2'd2
   } dht_event_type;

   localparam logic [CSR_IW-1:0] CSR_MAX_TIMED_OUT = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_COOLDOWN      = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_NOTIFY_EN     = 2'd2;

   typedef struct packed {
      logic            push;
      logic [TS_W-1:0] data;
   } dht_win_req_type;

   typedef struct packed {
      logic            busy;
      logic [TS_W-1:0] worst;
   } dht_win_sts_type;

endpackage

`default_nettype wire

>>> src/dht_window.sv
// ----------------------------------------------------------------------------
// dht_window
// ring of recent execution times in a synchronous memory; after each push
// the filled entries are read back one per cycle to find the largest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dht_window
   import dht_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dht_win_req_type win_req,
   output      dht_win_sts_type win_sts
);

   logic [TS_W-1:0]   mem [WIN_DEPTH];
   logic [TS_W-1:0]   rd_data_ff;
   logic [WIN_AW-1:0] wpos_ff;
   logic [WIN_FW-1:0] fill_ff;
   logic [WIN_FW-1:0] issue_ff;
   logic              pend_ff;
   logic              busy_ff;
   logic [TS_W-1:0]   worst_ff;

   always_ff @(posedge clock) begin
      if (win_req.push) begin
         mem[wpos_ff] <= win_req.data;
      end
      rd_data_ff <= mem[issue_ff[WIN_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff  <= '0;
         fill_ff  <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
         busy_ff  <= 1'b0;
         worst_ff <= '0;
      end else if (win_req.push) begin
         wpos_ff  <= (wpos_ff == WIN_AW'(WIN_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
         fill_ff  <= (fill_ff == WIN_FW'(WIN_DEPTH)) ? fill_ff : fill_ff + 1'b1;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
         busy_ff  <= 1'b1;
         worst_ff <= '0;
      end else if (busy_ff) begin
         if (issue_ff < fill_ff) begin
            issue_ff <= issue_ff + 1'b1;
            pend_ff  <= 1'b1;
         end else begin
            pend_ff <= 1'b0;
         end
         if (pend_ff && (rd_data_ff > worst_ff)) begin
            worst_ff <= rd_data_ff;
         end
         if ((issue_ff == fill_ff) && !pend_ff) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign win_sts.busy  = busy_ff;
   assign win_sts.worst = worst_ff;

endmodule

`default_nettype wire

>>> src/device_health_tracker.sv
// ----------------------------------------------------------------------------
// device_health_tracker
// health state of one storage device driven by request events
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  req     | in        | opcode, request_start_ts, now_ts, execution_time, notify
//  rsp     | out       | device_state, event_kind, event_time, worst_time
//  csr     | in        | write enable, register index, 64-bit data
//
//  one event at a time, through the idle, prep, diff, decide and done states
//  a success adds the window rescan, one memory read per filled entry,
//  and the result waits in the done state until the rescan ends
//  synchronous reset; the window memory holds no reset, its fill count does
//  a stalled result waits in the output register while the next event is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module device_health_tracker
   import dht_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [2:0]        req_opcode,
   input  wire logic [TS_W-1:0]   req_request_start_ts,
   input  wire logic [TS_W-1:0]   req_now_ts,
   input  wire logic [TS_W-1:0]   req_execution_time,
   input  wire logic              req_notify_request,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [1:0]        rsp_device_state,
   output      logic [1:0]        rsp_event_kind,
   output      logic [TS_W-1:0]   rsp_event_time,
   output      logic [TS_W-1:0]   rsp_worst_time,
   input  wire logic              csr_write_enable,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [TS_W-1:0]   csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_DIFF,
      S_DECIDE,
      S_DONE
   } fsm_type;

   fsm_type          state_ff;

   logic [TS_W-1:0]  max_to_ff;
   logic [TS_W-1:0]  cooldown_ff;
   logic             notify_en_ff;

   logic [1:0]       status_ff;
   logic [TS_W-1:0]  fts_ff;
   logic [TS_W-1:0]  lss_ff;
   logic [TS_W-1:0]  bs_ff;

   logic [2:0]       op_ff;
   logic [TS_W-1:0]  start_ff;
   logic [TS_W-1:0]  now_ff;
   logic [TS_W-1:0]  exec_ff;
   logic             notify_ff;

   logic             stale_ff;
   logic [TS_W-1:0]  fts_eff_ff;
   logic [TS_W:0]    sum_ff;
   logic [TS_W-1:0]  dur_ff;
   logic             cool_ff;
   logic [1:0]       ev_ff;
   logic [TS_W-1:0]  ev_time_ff;

   logic             rsp_valid_ff;
   logic [1:0]       rsp_state_ff;
   logic [1:0]       rsp_event_ff;
   logic [TS_W-1:0]  rsp_time_ff;
   logic [TS_W-1:0]  rsp_worst_ff;

   logic [TS_W:0]    diff;
   logic [TS_W-1:0]  sum_sat;

   logic [1:0]       status_in;
   logic [TS_W-1:0]  fts_in;
   logic [TS_W-1:0]  lss_in;
   logic [TS_W-1:0]  bs_in;
   logic [1:0]       ev_in;
   logic [TS_W-1:0]  ev_time_in;
   logic             push_in;

   dht_win_req_type  win_req;
   dht_win_sts_type  win_sts;
   logic             rsp_load;

   assign diff    = {1'b0, now_ff} - {1'b0, fts_eff_ff};
   assign sum_sat = sum_ff[TS_W] ? {TS_W{1'b1}} : sum_ff[TS_W-1:0];

   always_comb begin
      status_in  = status_ff;
      fts_in     = fts_ff;
      lss_in     = lss_ff;
      bs_in      = bs_ff;
      ev_in      = EV_NONE;
      ev_time_in = '0;
      push_in    = 1'b0;
      case (op_ff)
         OP_SUCCESS: begin
            fts_in    = '0;
            lss_in    = start_ff;
            bs_in     = '0;
            status_in = ST_OK;
            push_in   = 1'b1;
            if (status_ff == ST_SILENT_BROKEN || status_ff == ST_BROKEN) begin
               ev_in = EV_RECOVERED;
            end
         end
         OP_MARK_BROKEN: begin
            if (status_ff != ST_BROKEN) begin
               bs_in     = now_ff;
               status_in = ST_BROKEN;
               if (notify_ff) begin
                  ev_in      = EV_BROKEN;
                  ev_time_in = now_ff;
               end
            end
         end
         OP_UNAVAILABLE: begin
            status_in = ST_UNAVAILABLE;
         end
         OP_BACK_ONLINE: begin
            if (status_ff == ST_OK || status_ff == ST_UNAVAILABLE) begin
               status_in = ST_OK;
               fts_in    = '0;
            end
         end
         OP_TIMEOUT: begin
            if (!stale_ff) begin
               fts_in = fts_eff_ff;
               if (status_ff == ST_OK || status_ff == ST_UNAVAILABLE) begin
                  if (dur_ff > max_to_ff) begin
                     bs_in      = now_ff;
                     status_in  = ST_SILENT_BROKEN;
                     ev_in      = EV_BROKEN;
                     ev_time_in = now_ff;
                  end
               end else if (status_ff == ST_SILENT_BROKEN) begin
                  if (cool_ff) begin
                     status_in  = ST_BROKEN;
                     ev_in      = EV_BROKEN;
                     ev_time_in = now_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (!notify_en_ff) begin
         ev_in      = EV_NONE;
         ev_time_in = '0;
      end
   end

   assign win_req.push = (state_ff == S_DECIDE) && push_in;
   assign win_req.data = exec_ff;

   // result register takes a new beat once the scan is done and the slot frees
   assign rsp_load = (state_ff == S_DONE) && !win_sts.busy && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_to_ff    <= '0;
         cooldown_ff  <= '0;
         notify_en_ff <= 1'b1;
         status_ff    <= ST_OK;
         fts_ff       <= '0;
         lss_ff       <= '0;
         bs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_MAX_TIMED_OUT: max_to_ff    <= csr_write_data;
               CSR_COOLDOWN:      cooldown_ff  <= csr_write_data;
               CSR_NOTIFY_EN:     notify_en_ff <= csr_write_data[0];
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_opcode;
                  start_ff  <= req_request_start_ts;
                  now_ff    <= req_now_ts;
                  exec_ff   <= req_execution_time;
                  notify_ff <= req_notify_request;
                  state_ff  <= S_PREP;
               end
            end
            S_PREP: begin
               stale_ff   <= start_ff < lss_ff;
               fts_eff_ff <= (fts_ff == '0) ? start_ff : fts_ff;
               sum_ff     <= {1'b0, bs_ff} + {1'b0, cooldown_ff};
               state_ff   <= S_DIFF;
            end
            S_DIFF: begin
               dur_ff   <= ((fts_eff_ff != '0) && !diff[TS_W]) ? diff[TS_W-1:0] : '0;
               cool_ff  <= sum_sat < now_ff;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               status_ff  <= status_in;
               fts_ff     <= fts_in;
               lss_ff     <= lss_in;
               bs_ff      <= bs_in;
               ev_ff      <= ev_in;
               ev_time_ff <= ev_time_in;
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_state_ff <= status_ff;
                  rsp_event_ff <= ev_ff;
                  rsp_time_ff  <= ev_time_ff;
                  rsp_worst_ff <= win_sts.worst;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   dht_window u_window (
      .clock   (clock),
      .reset   (reset),
      .win_req (win_req),
      .win_sts (win_sts)
   );

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_device_state = rsp_state_ff;
   assign rsp_event_kind   = rsp_event_ff;
   assign rsp_event_time   = rsp_time_ff;
   assign rsp_worst_time   = rsp_worst_ff;

endmodule

`default_nettype wire

>>> src/dht_checker.sv
// ----------------------------------------------------------------------------
// dht_checker
// port-level checks on the health tracker result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "device_health_tracker_assert.svh"

module dht_checker
   import dht_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire logic [1:0]      rsp_device_state,
   input wire logic [1:0]      rsp_event_kind,
   input wire logic [TS_W-1:0] rsp_event_time,
   input wire logic [TS_W-1:0] rsp_worst_time
);

   logic [2*TS_W+3:0] rsp_beat;
   logic              rsp_down;

   assign rsp_beat = {rsp_device_state, rsp_event_kind, rsp_event_time, rsp_worst_time};
   assign rsp_down = (rsp_device_state == ST_SILENT_BROKEN) || (rsp_device_state == ST_BROKEN);

   `DHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `DHT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_beat))
   `DHT_ASSERT_NOW(a_time_only_broken, rsp_valid && (rsp_event_kind != EV_BROKEN), ~|rsp_event_time)
   `DHT_ASSERT_NOW(a_recovered_ok, rsp_valid && (rsp_event_kind == EV_RECOVERED), rsp_device_state == ST_OK)
   `DHT_ASSERT_NOW(a_broken_state, rsp_valid && (rsp_event_kind == EV_BROKEN), rsp_down)

endmodule

bind device_health_tracker dht_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the device health tracker: a scoreboard class
// predicts state, event and window worst for every accepted event beat and
// compares each result beat field by field; directed corner cases come first,
// then randomized event streams under several register settings, with idle
// bursts on both channels and one long result hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import dht_pkg::*;

   localparam int unsigned     RESET_CYCLES    = 11;
   localparam int unsigned     SETTLE_CYCLES   = 30;
   localparam int unsigned     HOLD_OFF_CYCLES = 250;
   localparam int unsigned     WATCHDOG_LIMIT  = 2000;
   localparam int unsigned     REPORT_LINES    = 40;
   localparam logic [TS_W-1:0] ALL_ONES        = '1;
   localparam logic [CSR_IW-1:0] CSR_UNUSED    = 2'd3;

   typedef struct packed {
      dht_status_type  state;
      dht_event_type   kind;
      logic [TS_W-1:0] event_us;
      logic [TS_W-1:0] worst_us;
   } health_result_type;

   class health_scoreboard;
      logic [TS_W-1:0]   timed_out_limit;
      logic [TS_W-1:0]   cooldown_us;
      logic              events_on;
      dht_status_type    status;
      logic [TS_W-1:0]   timeout_start;
      logic [TS_W-1:0]   last_success;
      logic [TS_W-1:0]   broken_since;
      logic [TS_W-1:0]   exec_window [WIN_DEPTH];
      int unsigned       window_fill;
      int unsigned       window_pos;
      health_result_type expected_q[$];
      int unsigned       op_count [8];
      int unsigned       broken_reports;
      int unsigned       recoveries;
      int unsigned       window_wraps;
      int unsigned       checked;
      int unsigned       mismatches;

      function new();
         timed_out_limit = '0;
         cooldown_us = '0;
         events_on = 1'b1;
         status = ST_OK;
         timeout_start = '0;
         last_success = '0;
         broken_since = '0;
         window_fill = 0;
         window_pos = 0;
         foreach (op_count[i]) op_count[i] = 0;
         broken_reports = 0;
         recoveries = 0;
         window_wraps = 0;
         checked = 0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [CSR_IW-1:0] index, logic [TS_W-1:0] data);
         case (index)
            CSR_MAX_TIMED_OUT: timed_out_limit = data;
            CSR_COOLDOWN:      cooldown_us = data;
            CSR_NOTIFY_EN:     events_on = data[0];
            default: ;
         endcase
      endfunction

      function void note_event(logic [2:0] op, logic [TS_W-1:0] start_us, now_us, exec_us,
                               logic notify);
         health_result_type r;
         dht_event_type     kind;
         logic [TS_W-1:0]   event_us;
         logic [TS_W-1:0]   spent;
         logic [TS_W:0]     due;
         logic              was_down;
         kind = EV_NONE;
         event_us = '0;
         op_count[op]++;
         case (op)
            OP_SUCCESS: begin
               was_down = (status == ST_SILENT_BROKEN || status == ST_BROKEN);
               timeout_start = '0;
               last_success = start_us;
               exec_window[window_pos] = exec_us;
               if (window_pos == WIN_DEPTH - 1) window_wraps++;
               window_pos = (window_pos + 1) % WIN_DEPTH;
               if (window_fill < WIN_DEPTH) window_fill++;
               status = ST_OK;
               broken_since = '0;
               if (was_down) kind = EV_RECOVERED;
            end
            OP_MARK_BROKEN: begin
               if (status != ST_BROKEN) begin
                  broken_since = now_us;
                  status = ST_BROKEN;
                  if (notify) begin
                     kind = EV_BROKEN;
                     event_us = now_us;
                  end
               end
            end
            OP_UNAVAILABLE: begin
               status = ST_UNAVAILABLE;
            end
            OP_BACK_ONLINE: begin
               if (status == ST_OK || status == ST_UNAVAILABLE) begin
                  status = ST_OK;
                  timeout_start = '0;
               end
            end
            OP_TIMEOUT: begin
               if (start_us >= last_success) begin
                  if (timeout_start == '0) timeout_start = start_us;
                  if (status == ST_OK || status == ST_UNAVAILABLE) begin
                     spent = (timeout_start != '0 && now_us > timeout_start) ?
                             now_us - timeout_start : '0;
                     if (spent > timed_out_limit) begin
                        broken_since = now_us;
                        status = ST_SILENT_BROKEN;
                        kind = EV_BROKEN;
                        event_us = now_us;
                     end
                  end else if (status == ST_SILENT_BROKEN) begin
                     // an overflowing sum saturates to all ones, which no time exceeds
                     due = {1'b0, broken_since} + {1'b0, cooldown_us};
                     if (!due[TS_W] && due[TS_W-1:0] < now_us) begin
                        status = ST_BROKEN;
                        kind = EV_BROKEN;
                        event_us = now_us;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (!events_on) begin
            kind = EV_NONE;
            event_us = '0;
         end
         if (kind == EV_BROKEN) broken_reports++;
         if (kind == EV_RECOVERED) recoveries++;
         r.state = status;
         r.kind = kind;
         r.event_us = event_us;
         r.worst_us = '0;
         for (int i = 0; i < window_fill; i++)
            if (exec_window[i] > r.worst_us) r.worst_us = exec_window[i];
         expected_q.push_back(r);
      endfunction

      task report(string msg);
         if (mismatches < REPORT_LINES) $display("MISMATCH %s", msg);
         mismatches++;
      endtask

      task check_result(logic [1:0] state, logic [1:0] kind, logic [TS_W-1:0] event_us,
                        worst_us);
         health_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with no event pending: state %0d event %0d",
                             state, kind));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (state !== want.state)
            report($sformatf("beat %0d device_state %0d, expected %0d",
                             checked, state, want.state));
         if (kind !== want.kind)
            report($sformatf("beat %0d event_kind %0d, expected %0d",
                             checked, kind, want.kind));
         if (event_us !== want.event_us)
            report($sformatf("beat %0d event_time %0h, expected %0h",
                             checked, event_us, want.event_us));
         if (worst_us !== want.worst_us)
            report($sformatf("beat %0d worst_time %0h, expected %0h",
                             checked, worst_us, want.worst_us));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_opcode = '0;
   logic [TS_W-1:0]   req_request_start_ts = '0;
   logic [TS_W-1:0]   req_now_ts = '0;
   logic [TS_W-1:0]   req_execution_time = '0;
   logic              req_notify_request = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_device_state;
   logic [1:0]        rsp_event_kind;
   logic [TS_W-1:0]   rsp_event_time;
   logic [TS_W-1:0]   rsp_worst_time;
   logic              csr_write_enable = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [TS_W-1:0]   csr_write_data = '0;

   health_scoreboard  sb;
   logic [TS_W-1:0]   clock_us = '0;
   logic              sender_gaps = 1'b1;
   logic              receiver_gaps = 1'b1;
   logic              hold_off_pending = 1'b0;
   int unsigned       quiet_cycles = 0;

   device_health_tracker dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_request_start_ts (req_request_start_ts),
      .req_now_ts           (req_now_ts),
      .req_execution_time   (req_execution_time),
      .req_notify_request   (req_notify_request),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_device_state     (rsp_device_state),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_event_time       (rsp_event_time),
      .rsp_worst_time       (rsp_worst_time),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_device_state, rsp_event_kind, rsp_event_time, rsp_worst_time);
         if (csr_write_enable) sb.write_reg(csr_index, csr_write_data);
         if (req_valid && req_ready)
            sb.note_event(req_opcode, req_request_start_ts, req_now_ts, req_execution_time,
                          req_notify_request);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [TS_W-1:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // valid stays high after the beat unless a gap follows
   task automatic send_event(logic [2:0] op, logic [TS_W-1:0] start_us, now_us, exec_us,
                             logic notify);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_request_start_ts <= start_us;
      req_now_ts <= now_us;
      req_execution_time <= exec_us;
      req_notify_request <= notify;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IW-1:0] index, logic [TS_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic random_event();
      int unsigned     pick;
      logic [TS_W-1:0] start_us;
      logic [TS_W-1:0] exec_us;
      pick = $urandom_range(0, 99);
      clock_us = clock_us + $urandom_range(0, 400);
      exec_us = ($urandom_range(0, 9) == 0) ? rand_word() : TS_W'($urandom_range(0, 5000));
      if (pick < 35) begin
         send_event(OP_SUCCESS, clock_us - $urandom_range(0, 200), clock_us, exec_us,
                    1'($urandom_range(0, 1)));
      end else if (pick < 70) begin
         start_us = ($urandom_range(0, 19) == 0) ? '0 : clock_us - $urandom_range(0, 3000);
         send_event(OP_TIMEOUT, start_us, clock_us, exec_us, 1'($urandom_range(0, 1)));
      end else if (pick < 78) begin
         send_event(OP_MARK_BROKEN, clock_us, clock_us, exec_us, 1'($urandom_range(0, 1)));
      end else if (pick < 86) begin
         send_event(OP_UNAVAILABLE, clock_us, clock_us, exec_us, 1'($urandom_range(0, 1)));
      end else if (pick < 93) begin
         send_event(OP_BACK_ONLINE, clock_us, clock_us, exec_us, 1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
         send_event(3'($urandom_range(OP_TIMEOUT + 1, 7)), clock_us, clock_us, exec_us,
                    1'($urandom_range(0, 1)));
      end else begin
         send_event(3'($urandom_range(0, 7)), rand_word(), rand_word(), rand_word(),
                    1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(logic [TS_W-1:0] limit_us, cooldown_val, notify_word, base_us,
                            int unsigned count, logic hold, logic touch_unused);
      quiesce();
      csr_write(CSR_MAX_TIMED_OUT, limit_us);
      csr_write(CSR_COOLDOWN, cooldown_val);
      csr_write(CSR_NOTIFY_EN, notify_word);
      if (touch_unused) csr_write(CSR_UNUSED, rand_word());
      csr_write_enable <= 1'b0;
      if (hold) hold_off_pending = 1'b1;
      clock_us = base_us;
      repeat (count) random_event();
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero limit, zero cooldown, events on
      for (int code = OP_TIMEOUT + 1; code < 8; code++)
         send_event(3'(code), ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
      send_event(OP_TIMEOUT, '0, 64'd1000, '0, 1'b0);
      send_event(OP_TIMEOUT, 64'd500, 64'd400, '0, 1'b0);
      send_event(OP_TIMEOUT, 64'd600, 64'd501, '0, 1'b0);
      send_event(OP_TIMEOUT, 64'd700, 64'd501, '0, 1'b0);
      send_event(OP_TIMEOUT, 64'd700, 64'd502, '0, 1'b0);
      send_event(OP_TIMEOUT, 64'd900, 64'd5000, '0, 1'b1);
      send_event(OP_BACK_ONLINE, '0, '0, '0, 1'b0);
      send_event(OP_MARK_BROKEN, '0, 64'd6000, '0, 1'b1);
      send_event(OP_SUCCESS, 64'd800, 64'd7000, ALL_ONES, 1'b0);
      send_event(OP_SUCCESS, '0, '0, '0, 1'b1);
      send_event(OP_MARK_BROKEN, '0, ALL_ONES, '0, 1'b1);
      send_event(OP_SUCCESS, 64'd1000, 64'd8000, 64'd12345, 1'b0);
      send_event(OP_UNAVAILABLE, '0, '0, '0, 1'b0);
      send_event(OP_MARK_BROKEN, '0, 64'd9000, '0, 1'b0);
      send_event(OP_UNAVAILABLE, '0, '0, '0, 1'b0);
      send_event(OP_BACK_ONLINE, '0, '0, '0, 1'b0);
      send_event(OP_TIMEOUT, ALL_ONES, ALL_ONES, '0, 1'b0);
      send_event(OP_TIMEOUT, 64'd2000, '0, '0, 1'b0);

      // cooldown sum wrapping past the top of the time range
      quiesce();
      csr_write(CSR_COOLDOWN, 64'd100);
      csr_write_enable <= 1'b0;
      send_event(OP_SUCCESS, 64'd1, 64'd1, 64'd7, 1'b0);
      send_event(OP_TIMEOUT, ALL_ONES - 64'd29, ALL_ONES - 64'd9, '0, 1'b0);
      send_event(OP_TIMEOUT, ALL_ONES - 64'd29, ALL_ONES, '0, 1'b0);
      send_event(OP_BACK_ONLINE, '0, '0, '0, 1'b0);

      run_phase('0, '0, 64'd1, 64'd10000, 150, 1'b0, 1'b0);
      run_phase(ALL_ONES, ALL_ONES, 64'd1, ALL_ONES - 64'd1000000, 120, 1'b0, 1'b0);
      run_phase(64'd500, 64'd800, rand_word() << 1, 64'd20000, 150, 1'b1, 1'b0);
      run_phase(64'd1500, 64'd300, (rand_word() << 1) | 64'd1, 64'd30000, 170, 1'b0, 1'b1);
      run_phase(TS_W'($urandom_range(0, 3000)), TS_W'($urandom_range(0, 3000)), 64'd1,
                64'd40000, 170, 1'b0, 1'b0);
      run_phase(64'd200, 64'd2000, 64'd1, 64'd50000, 170, 1'b0, 1'b0);
      quiesce();
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      run_phase(TS_W'($urandom_range(0, 1000)), TS_W'($urandom_range(0, 1000)), 64'd1,
                64'd60000, 150, 1'b0, 1'b0);
      quiesce();

      $display({"events: %0d success, %0d timeout, %0d mark broken, %0d unavailable, ",
                "%0d back online, %0d unused codes"},
               sb.op_count[OP_SUCCESS], sb.op_count[OP_TIMEOUT], sb.op_count[OP_MARK_BROKEN],
               sb.op_count[OP_UNAVAILABLE], sb.op_count[OP_BACK_ONLINE],
               sb.op_count[5] + sb.op_count[6] + sb.op_count[7]);
      $display({"%0d results checked, %0d broken and %0d recovery reports, ",
                "window wrapped %0d times, %0d mismatches"},
               sb.checked, sb.broken_reports, sb.recoveries, sb.window_wraps, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/dht_pkg.sv
src/dht_window.sv
src/device_health_tracker.sv
src/dht_checker.sv
tb/sv/tb_top.sv
